FILE: design/contour_sampson_ellipse_check_assert.svh
// assertion macros for the conic fit check block
`ifndef CONTOUR_SAMPSON_ELLIPSE_CHECK_ASSERT_SVH
`define CONTOUR_SAMPSON_ELLIPSE_CHECK_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define CSEC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csec assertion failed");
// next-cycle implication
`define CSEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csec assertion failed");
`else
`define CSEC_ASSERT_NOW(lbl, ante, cons)
`define CSEC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: design/csec_pkg.sv
// shared types and constants for the conic fit check block
`timescale 1ns / 1ps
`default_nettype none
package csec_pkg;

  localparam int PT_W    = 12;   // coordinate field width
  localparam int COEF_W  = 48;   // signed Q15.32 coefficient
  localparam int LIM_W   = 32;
  localparam int DIST_W  = 32;   // unsigned Q16.16 distance
  localparam int SUM_W   = 44;
  localparam int DG_W    = 8;    // multiplier digit width
  localparam int XD      = 2;    // digits of a coordinate
  localparam int XI_W    = 1;
  localparam int AX_W    = 62;   // gradient half terms
  localparam int AXD     = 8;
  localparam int AXI_W   = 3;
  localparam int Q_W     = 76;   // conic value
  localparam int QD      = 10;
  localparam int QI_W    = 4;
  localparam int A_W     = 76;   // multiplier wide operand
  localparam int ACC_W   = 150;
  localparam int Q2_W    = 148;
  localparam int S_W     = 121;  // sum of squared gradient halves
  localparam int DIV_NW  = 160;
  localparam int DIV_DW  = 121;
  localparam int DIV_SH  = 12;   // q^2 * 2^12 / s gives the Q16.16 distance
  localparam int ADDR_W  = 6;
  localparam int PDATA_W = 64;
  localparam int STEP_W  = 5;

  localparam logic [DIST_W-1:0] DIST_TOP = '1;
  localparam logic [SUM_W-1:0]  SUM_TOP  = '1;
  localparam logic [LIM_W-1:0]  AVG_RST  = 32'd131072;
  localparam logic [LIM_W-1:0]  MAXL_RST = 32'd327680;

  // last step and capture step of each sequencer phase
  localparam logic [STEP_W-1:0] AX_LAST = STEP_W'(2 * XD);
  localparam logic [STEP_W-1:0] AX_END  = STEP_W'(2 * XD + 1);
  localparam logic [STEP_W-1:0] QV_LAST = STEP_W'(4 * XD);
  localparam logic [STEP_W-1:0] QV_END  = STEP_W'(4 * XD + 1);
  localparam logic [STEP_W-1:0] Q2_END  = STEP_W'(QD);
  localparam logic [STEP_W-1:0] SQ_END  = STEP_W'(2 * AXD);

  typedef enum logic [2:0] {
    REG_XX   = 3'd0,
    REG_XY   = 3'd1,
    REG_X1   = 3'd2,
    REG_YY   = 3'd3,
    REG_Y1   = 3'd4,
    REG_11   = 3'd5,
    REG_AVGL = 3'd6,
    REG_MAXL = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic shift;
  } mac_op_t;

  typedef struct packed {
    logic start;
    logic zero_top;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

  function automatic logic signed [A_W-1:0] ext_coef(input logic [COEF_W-1:0] c);
    return A_W'($signed(c));
  endfunction

endpackage
`default_nettype wire

FILE: design/csec_in_if.sv
// point request channel
`timescale 1ns / 1ps
`default_nettype none
interface csec_in_if import csec_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PT_W-1:0] point_x;
  logic [PT_W-1:0] point_y;
  logic            last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface
`default_nettype wire

FILE: design/csec_out_if.sv
// contour result channel
`timescale 1ns / 1ps
`default_nettype none
interface csec_out_if import csec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] mean_distance;
  logic [DIST_W-1:0] max_distance;
  logic              is_ellipse;

  modport source (output valid, mean_distance, max_distance, is_ellipse, input ready);
  modport sink (input valid, mean_distance, max_distance, is_ellipse, output ready);
endinterface
`default_nettype wire

FILE: design/csec_mac.sv
// shared digit-serial multiply-accumulate unit
`timescale 1ns / 1ps
`default_nettype none
module csec_mac import csec_pkg::*; (
  input  wire logic                    clk,
  input  wire mac_op_t                 op,
  input  wire logic signed [A_W-1:0]   a,
  input  wire logic [DG_W-1:0]         digit,
  output logic signed [ACC_W-1:0]      acc
);

  logic signed [ACC_W-1:0]     acc_r;
  logic signed [ACC_W-1:0]     acc_nxt;
  logic signed [ACC_W-1:0]     base;
  logic signed [A_W+DG_W:0]    prod;

  always_comb begin
    prod = a * $signed({1'b0, digit});
    if (op.clr) begin
      base = '0;
    end else if (op.shift) begin
      base = acc_r <<< DG_W;   // horner step, one digit up
    end else begin
      base = acc_r;
    end
    acc_nxt = base + ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

FILE: design/csec_div.sv
// iterative restoring divider with saturation to a 32-bit quotient
`timescale 1ns / 1ps
`default_nettype none
module csec_div import csec_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire div_req_t           req,
  input  wire logic [DIV_NW-1:0]  num,
  input  wire logic [DIV_DW-1:0]  den,
  output div_rsp_t                rsp,
  output logic [DIST_W-1:0]       quo
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_CHK  = 3'b010,
    D_RUN  = 3'b100
  } dstate_t;

  dstate_t             state_r, state_nxt;
  logic [4:0]          bit_r, bit_nxt;
  logic                done_r, done_nxt;
  logic                zt_r;
  logic [DIV_NW-1:0]   rem_r;
  logic [DIV_NW-1:0]   dsh_r;
  logic [DIST_W-1:0]   quo_r;
  logic                ge;
  logic                sat;

  assign ge  = rem_r >= dsh_r;
  // quotient would need 33 bits or more
  assign sat = {1'b0, rem_r} >= {dsh_r, 1'b0};

  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      D_IDLE: begin
        if (req.start) begin
          state_nxt = D_CHK;
        end
      end
      D_CHK: begin
        bit_nxt = '0;
        if (dsh_r == '0 || sat) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end else begin
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        bit_nxt = bit_r + 5'd1;
        if (bit_r == 5'(DIST_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      bit_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      D_IDLE: begin
        if (req.start) begin
          rem_r <= num;
          dsh_r <= DIV_NW'(den) << (DIST_W - 1);
          zt_r  <= req.zero_top;
        end
      end
      D_CHK: begin
        if (dsh_r == '0) begin
          quo_r <= zt_r ? DIST_TOP : '0;
        end else if (sat) begin
          quo_r <= DIST_TOP;
        end else begin
          quo_r <= '0;
        end
      end
      D_RUN: begin
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        quo_r <= {quo_r[DIST_W-2:0], ge};
        dsh_r <= dsh_r >> 1;
      end
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign quo      = quo_r;

endmodule
`default_nettype wire

FILE: design/contour_sampson_ellipse_check.sv
// top level of the conic fit check block
`timescale 1ns / 1ps
`default_nettype none
`include "contour_sampson_ellipse_check_assert.svh"
// Checks the contour points of one candidate ellipse against a symmetric conic
// matrix held in registers. Each point request (x, y, last) yields a
// Sampson-style distance q^2 / (4 (Jx^2 + Jy^2)) in unsigned Q16.16, floored and
// saturated to all ones (also when the gradient is zero). Distances are summed
// (saturating at 44 bits, counting at most MAX_POINTS points) and their peak is
// kept; the point marked last produces one result: the mean, the peak and an
// is_ellipse flag (mean below avg_limit and peak below max_limit), and the
// running state is cleared for the next contour. One point is handled at a
// time and in_ch.ready is low while it is worked on. Each point runs through
// a single 76 x 8 bit multiply-accumulate unit stepped one digit a cycle
// through the gradient terms, the conic value and the squares, followed by
// one 32-step restoring divider, which is used again for the mean on the last
// point. A result waits in the output register until taken; the next point may
// be accepted meanwhile. Registers sit on an APB-style port, 64-bit data,
// register i at byte address 8*i; they should be written only while the block
// is idle.
module contour_sampson_ellipse_check import csec_pkg::*; #(
  parameter int MAX_POINTS = 4096,
  parameter int COORD_BITS = 12
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  csec_in_if.sink                  in_ch,
  csec_out_if.source               out_ch,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  localparam int MW    = (COORD_BITS < PT_W) ? COORD_BITS : PT_W;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_AX   = 10'b00_0000_0010,   // xx*x + xy*y + x1
    S_AY   = 10'b00_0000_0100,   // yy*y + xy*x + y1
    S_QV   = 10'b00_0000_1000,   // conic value
    S_Q2   = 10'b00_0001_0000,   // conic value squared
    S_SQ   = 10'b00_0010_0000,   // sum of squared gradient halves
    S_DDIV = 10'b00_0100_0000,   // distance division
    S_ACC  = 10'b00_1000_0000,   // sum, count and peak update
    S_MDIV = 10'b01_0000_0000,   // mean division
    S_EMIT = 10'b10_0000_0000
  } state_t;

  // configuration registers
  logic [COEF_W-1:0] cxx_r, cxy_r, cx1_r, cyy_r, cy1_r, c11_r;
  logic [LIM_W-1:0]  avg_r, maxl_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  // sequencer and datapath state
  state_t                  state_r, state_nxt;
  logic [STEP_W-1:0]       cnt_r, cnt_nxt;
  logic [PT_W-1:0]         x_r, y_r;
  logic                    last_r;
  logic signed [AX_W-1:0]  ax_r, ay_r;
  logic [AX_W-1:0]         axm_r, aym_r;
  logic [Q_W-1:0]          qm_r;
  logic [Q2_W-1:0]         q2_r;
  logic [DIST_W-1:0]       dist_r;
  logic [SUM_W-1:0]        sum_r;
  logic [CNT_W-1:0]        count_r;
  logic [DIST_W-1:0]       peak_r;

  // result register
  logic                    out_valid_r;
  logic [DIST_W-1:0]       mean_r, max_r;
  logic                    ell_r;

  // shared units
  mac_op_t                 mop;
  logic signed [A_W-1:0]   ma;
  logic [DG_W-1:0]         mdig;
  logic signed [ACC_W-1:0] acc;
  div_req_t                dreq;
  div_rsp_t                drsp;
  logic [DIV_NW-1:0]       dnum;
  logic [DIV_DW-1:0]       dden;
  logic [DIST_W-1:0]       dquo;

  logic [XD*DG_W-1:0]      x_pad, y_pad;
  logic [AXD*DG_W-1:0]     axm_pad, aym_pad;
  logic [QD*DG_W-1:0]      qm_pad;
  logic [XI_W-1:0]         xi2, xi4;
  logic [AXI_W-1:0]        ai;
  logic [QI_W-1:0]         qi;
  logic                    in_acc;
  logic                    out_free;
  logic [SUM_W:0]          sum_add;
  logic [SUM_W-1:0]        sum_nxt;
  logic [CNT_W-1:0]        count_nxt;
  logic                    room;
  logic signed [AX_W-1:0]  acc_ax;
  logic signed [Q_W-1:0]   acc_q;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cxx_r  <= '0;
      cxy_r  <= '0;
      cx1_r  <= '0;
      cyy_r  <= '0;
      cy1_r  <= '0;
      c11_r  <= '0;
      avg_r  <= AVG_RST;
      maxl_r <= MAXL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_XX:   cxx_r  <= pwdata[COEF_W-1:0];
        REG_XY:   cxy_r  <= pwdata[COEF_W-1:0];
        REG_X1:   cx1_r  <= pwdata[COEF_W-1:0];
        REG_YY:   cyy_r  <= pwdata[COEF_W-1:0];
        REG_Y1:   cy1_r  <= pwdata[COEF_W-1:0];
        REG_11:   c11_r  <= pwdata[COEF_W-1:0];
        REG_AVGL: avg_r  <= pwdata[LIM_W-1:0];
        REG_MAXL: maxl_r <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_XX:   prdata = PDATA_W'(cxx_r);
      REG_XY:   prdata = PDATA_W'(cxy_r);
      REG_X1:   prdata = PDATA_W'(cx1_r);
      REG_YY:   prdata = PDATA_W'(cyy_r);
      REG_Y1:   prdata = PDATA_W'(cy1_r);
      REG_11:   prdata = PDATA_W'(c11_r);
      REG_AVGL: prdata = PDATA_W'(avg_r);
      REG_MAXL: prdata = PDATA_W'(maxl_r);
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshakes
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // ---------------------------------------------------------------- digit selection
  assign x_pad   = (XD*DG_W)'(x_r);
  assign y_pad   = (XD*DG_W)'(y_r);
  assign axm_pad = (AXD*DG_W)'(axm_r);
  assign aym_pad = (AXD*DG_W)'(aym_r);
  assign qm_pad  = (QD*DG_W)'(qm_r);

  // digits run from the most significant down (horner order)
  assign xi2 = XI_W'(XD - 1) - cnt_r[XI_W:1];       // two products a digit
  assign xi4 = XI_W'(XD - 1) - cnt_r[XI_W+1:2];     // four products a digit
  assign ai  = AXI_W'(AXD - 1) - cnt_r[AXI_W:1];
  assign qi  = QI_W'(QD - 1) - cnt_r[QI_W-1:0];

  // ---------------------------------------------------------------- mac micro-ops
  always_comb begin
    mop   = '0;
    ma    = '0;
    mdig  = '0;
    mop.clr = (cnt_r == '0);
    unique case (state_r)
      S_AX: begin
        if (cnt_r == AX_LAST) begin
          mop.en = 1'b1;
          ma     = ext_coef(cx1_r);
          mdig   = DG_W'(1);
        end else if (cnt_r < AX_LAST) begin
          mop.en = 1'b1;
          if (!cnt_r[0]) begin
            mop.shift = 1'b1;
            ma        = ext_coef(cxx_r);
            mdig      = x_pad[xi2*DG_W +: DG_W];
          end else begin
            ma   = ext_coef(cxy_r);
            mdig = y_pad[xi2*DG_W +: DG_W];
          end
        end
      end
      S_AY: begin
        if (cnt_r == AX_LAST) begin
          mop.en = 1'b1;
          ma     = ext_coef(cy1_r);
          mdig   = DG_W'(1);
        end else if (cnt_r < AX_LAST) begin
          mop.en = 1'b1;
          if (!cnt_r[0]) begin
            mop.shift = 1'b1;
            ma        = ext_coef(cyy_r);
            mdig      = y_pad[xi2*DG_W +: DG_W];
          end else begin
            ma   = ext_coef(cxy_r);
            mdig = x_pad[xi2*DG_W +: DG_W];
          end
        end
      end
      S_QV: begin
        // q = ax*x + ay*y + x1*x + y1*y + c11
        if (cnt_r == QV_LAST) begin
          mop.en = 1'b1;
          ma     = ext_coef(c11_r);
          mdig   = DG_W'(1);
        end else if (cnt_r < QV_LAST) begin
          mop.en = 1'b1;
          unique case (cnt_r[1:0])
            2'd0: begin
              mop.shift = 1'b1;
              ma        = ext_coef(cx1_r);
              mdig      = x_pad[xi4*DG_W +: DG_W];
            end
            2'd1: begin
              ma   = A_W'(ax_r);
              mdig = x_pad[xi4*DG_W +: DG_W];
            end
            2'd2: begin
              ma   = A_W'(ay_r);
              mdig = y_pad[xi4*DG_W +: DG_W];
            end
            default: begin
              ma   = ext_coef(cy1_r);
              mdig = y_pad[xi4*DG_W +: DG_W];
            end
          endcase
        end
      end
      S_Q2: begin
        if (cnt_r < Q2_END) begin
          mop.en    = 1'b1;
          mop.shift = 1'b1;
          ma        = $signed(A_W'(qm_r));
          mdig      = qm_pad[qi*DG_W +: DG_W];
        end
      end
      S_SQ: begin
        if (cnt_r < SQ_END) begin
          mop.en = 1'b1;
          if (!cnt_r[0]) begin
            mop.shift = 1'b1;
            ma        = $signed(A_W'(axm_r));
            mdig      = axm_pad[ai*DG_W +: DG_W];
          end else begin
            ma   = $signed(A_W'(aym_r));
            mdig = aym_pad[ai*DG_W +: DG_W];
          end
        end
      end
      default: ;
    endcase
  end

  csec_mac u_mac (
    .clk   (clk),
    .op    (mop),
    .a     (ma),
    .digit (mdig),
    .acc   (acc)
  );

  assign acc_ax = acc[AX_W-1:0];
  assign acc_q  = acc[Q_W-1:0];

  // ---------------------------------------------------------------- contour state update
  assign room      = count_r < CNT_W'(MAX_POINTS);
  assign sum_add   = {1'b0, sum_r} + (SUM_W+1)'(dist_r);
  assign sum_nxt   = !room ? sum_r : (sum_add[SUM_W] ? SUM_TOP : sum_add[SUM_W-1:0]);
  assign count_nxt = room ? count_r + CNT_W'(1) : count_r;

  // ---------------------------------------------------------------- divider requests
  always_comb begin
    dreq = '0;
    if (state_r == S_SQ && cnt_r == SQ_END) begin
      // distance: q^2 * 2^12 / (ax^2 + ay^2), zero gradient saturates
      dreq.start    = 1'b1;
      dreq.zero_top = 1'b1;
      dnum          = {q2_r, DIV_SH'(0)};
      dden          = acc[S_W-1:0];
    end else begin
      // mean: sum / count
      dreq.start = (state_r == S_ACC) && last_r;
      dnum       = DIV_NW'(sum_nxt);
      dden       = DIV_DW'(count_nxt);
    end
  end

  csec_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .num   (dnum),
    .den   (dden),
    .rsp   (drsp),
    .quo   (dquo)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + STEP_W'(1);
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          state_nxt = S_AX;
        end
      end
      S_AX: begin
        if (cnt_r == AX_END) begin
          state_nxt = S_AY;
          cnt_nxt   = '0;
        end
      end
      S_AY: begin
        if (cnt_r == AX_END) begin
          state_nxt = S_QV;
          cnt_nxt   = '0;
        end
      end
      S_QV: begin
        if (cnt_r == QV_END) begin
          state_nxt = S_Q2;
          cnt_nxt   = '0;
        end
      end
      S_Q2: begin
        if (cnt_r == Q2_END) begin
          state_nxt = S_SQ;
          cnt_nxt   = '0;
        end
      end
      S_SQ: begin
        if (cnt_r == SQ_END) begin
          state_nxt = S_DDIV;
          cnt_nxt   = '0;
        end
      end
      S_DDIV: begin
        cnt_nxt = '0;
        if (drsp.done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cnt_nxt   = '0;
        state_nxt = last_r ? S_MDIV : S_IDLE;
      end
      S_MDIV: begin
        cnt_nxt = '0;
        if (drsp.done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cnt_nxt = '0;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_ACC) begin
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
        if (dist_r > peak_r) begin
          peak_r <= dist_r;
        end
      end
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        sum_r       <= '0;
        count_r     <= '0;
        peak_r      <= '0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // operand and result captures; each mac result is taken the cycle after its phase's last mac step
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r    <= PT_W'(in_ch.point_x[MW-1:0]);
      y_r    <= PT_W'(in_ch.point_y[MW-1:0]);
      last_r <= in_ch.last_point;
    end
    if (state_r == S_AX && cnt_r == AX_END) begin
      ax_r  <= acc_ax;
      axm_r <= acc_ax[AX_W-1] ? AX_W'(-acc_ax) : AX_W'(acc_ax);
    end
    if (state_r == S_AY && cnt_r == AX_END) begin
      ay_r  <= acc_ax;
      aym_r <= acc_ax[AX_W-1] ? AX_W'(-acc_ax) : AX_W'(acc_ax);
    end
    if (state_r == S_QV && cnt_r == QV_END) begin
      qm_r <= acc_q[Q_W-1] ? Q_W'(-acc_q) : Q_W'(acc_q);
    end
    if (state_r == S_Q2 && cnt_r == Q2_END) begin
      q2_r <= acc[Q2_W-1:0];
    end
    if (state_r == S_DDIV && drsp.done) begin
      dist_r <= dquo;
    end
    if (state_r == S_EMIT && out_free) begin
      mean_r <= dquo;
      max_r  <= peak_r;
      ell_r  <= (dquo < avg_r) && (peak_r < maxl_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mean_distance = mean_r;
  assign out_ch.max_distance  = max_r;
  assign out_ch.is_ellipse    = ell_r;

  // ---------------------------------------------------------------- checks
  // divider finishes only while the sequencer waits for it
  `CSEC_ASSERT_NOW(a_div_done_wait, drsp.done, (state_r == S_DDIV || state_r == S_MDIV))
  // point count is capped
  `CSEC_ASSERT_NOW(a_count_cap, 1'b1, (count_r <= CNT_W'(MAX_POINTS)))
  // a delivered result leaves the contour state cleared
  `CSEC_ASSERT_NEXT(a_emit_clear, (state_r == S_EMIT && out_free),
                    (out_ch.valid && sum_r == '0 && count_r == '0 && peak_r == '0))
  // peak never falls below the latest distance
  `CSEC_ASSERT_NEXT(a_peak_track, (state_r == S_ACC), (peak_r >= $past(dist_r)))

endmodule
`default_nettype wire

FILE: tb/sv/contour_sampson_ellipse_check_scoreboard.sv
// conic fit checker: predicts contour results and compares them with the block
`timescale 1ns / 1ps
`default_nettype none
module contour_sampson_ellipse_check_scoreboard import csec_pkg::*; #(
  parameter int MAX_POINTS = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  csec_in_if                in_ch,
  csec_out_if               out_ch,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic         cfg_pready,
  input  wire logic [ADDR_W-1:0]  cfg_paddr,
  input  wire logic [PDATA_W-1:0] cfg_pwdata,
  output int                fail_count,
  output int                pending_results
);

  typedef struct packed {
    logic [DIST_W-1:0] mean_distance;
    logic [DIST_W-1:0] max_distance;
    logic              is_ellipse;
  } contour_verdict_t;

  logic signed [COEF_W-1:0] conic [6];
  logic [LIM_W-1:0]  avg_lim, max_lim;
  logic [SUM_W-1:0]  dist_sum;
  logic [DIST_W-1:0] dist_peak;
  int                pt_count;
  contour_verdict_t  verdicts [$];

  assign pending_results = verdicts.size();

  // exact sampson distance in unsigned Q16.16, floored and saturated
  function automatic logic [DIST_W-1:0] sampson_distance(logic [PT_W-1:0] x, logic [PT_W-1:0] y);
    logic signed [255:0] sx, sy, cxx, cxy, cx1, cyy, cy1, c11, qv, jx, jy;
    logic [255:0] num, den, quo;
    sx  = $signed({244'd0, x});
    sy  = $signed({244'd0, y});
    cxx = conic[REG_XX];
    cxy = conic[REG_XY];
    cx1 = conic[REG_X1];
    cyy = conic[REG_YY];
    cy1 = conic[REG_Y1];
    c11 = conic[REG_11];
    qv  = cxx * sx * sx + 2 * cxy * sx * sy + 2 * cx1 * sx + cyy * sy * sy + 2 * cy1 * sy + c11;
    jx  = 2 * (cxx * sx + cxy * sy + cx1);
    jy  = 2 * (cyy * sy + cxy * sx + cy1);
    num = (qv * qv) << 16;
    den = 4 * (jx * jx + jy * jy);
    if (den == 0) return DIST_TOP;
    quo = num / den;
    if (quo > 256'(DIST_TOP)) return DIST_TOP;
    return quo[DIST_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [DIST_W-1:0] d;
    logic [SUM_W:0]    s;
    logic [SUM_W-1:0]  m;
    contour_verdict_t  v, got;
    if (!rst_n) begin
      foreach (conic[i]) conic[i] = '0;
      avg_lim    = AVG_RST;
      max_lim    = MAXL_RST;
      dist_sum   = '0;
      dist_peak  = '0;
      pt_count   = 0;
      fail_count = 0;
      verdicts.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[5:3]))
          REG_AVGL: avg_lim = cfg_pwdata[LIM_W-1:0];
          REG_MAXL: max_lim = cfg_pwdata[LIM_W-1:0];
          default:  conic[cfg_paddr[5:3]] = cfg_pwdata[COEF_W-1:0];
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        d = sampson_distance(in_ch.point_x, in_ch.point_y);
        if (pt_count < MAX_POINTS) begin
          s = dist_sum + d;
          dist_sum = (s > SUM_TOP) ? SUM_TOP : s[SUM_W-1:0];
          pt_count++;
        end
        if (d > dist_peak) dist_peak = d;
        if (in_ch.last_point) begin
          m = dist_sum / pt_count;
          v.mean_distance = (m > DIST_TOP) ? DIST_TOP : m[DIST_W-1:0];
          v.max_distance  = dist_peak;
          v.is_ellipse    = (v.mean_distance < avg_lim) && (dist_peak < max_lim);
          verdicts = {verdicts, v};
          dist_sum  = '0;
          dist_peak = '0;
          pt_count  = 0;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.mean_distance, out_ch.max_distance, out_ch.is_ellipse};
        if (verdicts.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: expected none, actual %h", $realtime, got);
        end else begin
          v = verdicts.pop_front();
          if (got.mean_distance !== v.mean_distance) begin
            fail_count++;
            $display("%0t mean_distance mismatch: expected %h, actual %h", $realtime,
                     v.mean_distance, got.mean_distance);
          end
          if (got.max_distance !== v.max_distance) begin
            fail_count++;
            $display("%0t max_distance mismatch: expected %h, actual %h", $realtime,
                     v.max_distance, got.max_distance);
          end
          if (got.is_ellipse !== v.is_ellipse) begin
            fail_count++;
            $display("%0t is_ellipse mismatch: expected %b, actual %b", $realtime,
                     v.is_ellipse, got.is_ellipse);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/contour_sampson_ellipse_check_tb.sv
// top of the conic fit check testbench: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps
`default_nettype none
module contour_sampson_ellipse_check_tb;
  import csec_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;   // idle cycles before giving up
  localparam int DRAIN_CYCLES   = 250;     // extra wait once every expected result is back

  logic clk;
  logic rst_n;

  csec_in_if  in_ch ();
  csec_out_if out_ch ();

  logic               cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [ADDR_W-1:0]  cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata, cfg_prdata;

  int  fail_count, pending_results;
  int  points_sent, contours_sent, results_taken;
  bit  calm;       // no idling on either side at the end of the run
  bit  hold_req;   // stimulus asks the result side for its long hold
  bit  long_hold_done;
  int  idle_cycles;

  // circle geometry for well-formed contours
  int  ctr_x, ctr_y, radius;

  contour_sampson_ellipse_check u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready)
  );

  contour_sampson_ellipse_check_scoreboard u_scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: counts cycles in which no request, result or register write moves
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: nothing moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) results_taken <= results_taken + 1;
  end

  // result side: random stall bursts, and once a long hold so the block backs up
  initial begin
    out_ch.ready = 1'b0;
    long_hold_done = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && !long_hold_done && hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // two-phase register write, register i at byte address 8*i
  task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(idx) << 3;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic load_conic(longint cxx, longint cxy, longint cx1, longint cyy,
                            longint cy1, longint c11, logic [31:0] avg, logic [31:0] mx);
    write_reg(REG_XX, 64'(cxx));
    write_reg(REG_XY, 64'(cxy));
    write_reg(REG_X1, 64'(cx1));
    write_reg(REG_YY, 64'(cyy));
    write_reg(REG_Y1, 64'(cy1));
    write_reg(REG_11, 64'(c11));
    write_reg(REG_AVGL, 64'(avg));
    write_reg(REG_MAXL, 64'(mx));
  endtask

  // circle (x-cx)^2 + (y-cy)^2 = r^2 scaled by k, optionally skewed by a cross term
  task automatic load_circle(int cx, int cy, int r, int scale_log2, bit skew,
                             logic [31:0] avg, logic [31:0] mx);
    longint k;
    k = longint'(1) << scale_log2;
    ctr_x  = cx;
    ctr_y  = cy;
    radius = r;
    load_conic(k, skew ? k / 8 : 0, -k * cx, k, -k * cy,
               k * (longint'(cx) * cx + longint'(cy) * cy - longint'(r) * r), avg, mx);
  endtask

  // one point request; valid stays high between back-to-back requests
  task automatic send_point(int x, int y, bit last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    if (x < 0) x = 0;
    if (x > 4095) x = 4095;
    if (y < 0) y = 0;
    if (y > 4095) y = 4095;
    in_ch.valid      <= 1'b1;
    in_ch.point_x    <= PT_W'(x);
    in_ch.point_y    <= PT_W'(y);
    in_ch.last_point <= last;
    do @(posedge clk); while (!in_ch.ready);
    points_sent++;
    if (last) contours_sent++;
  endtask

  // point near the current circle, mostly on it with a little jitter
  task automatic send_circle_point(bit last, int jitter);
    int dx, dy;
    dx = $urandom_range(0, 2 * radius) - radius;
    dy = int'($sqrt(real'(radius * radius - dx * dx)));
    if ($urandom_range(0, 1)) dy = -dy;
    send_point(ctr_x + dx + $urandom_range(0, 2 * jitter) - jitter,
               ctr_y + dy + $urandom_range(0, 2 * jitter) - jitter, last);
  endtask

  // wait until every expected result is back and the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 20 << 16);
    endcase
  endfunction

  function automatic longint rand_coef();
    longint c;
    c = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0:       return 64'sh0000_7FFF_FFFF_FFFF;
      1:       return -(longint'(1) << 47);
      default: return (c <<< 16) >>> ($urandom_range(16, 40));
    endcase
  endfunction

  initial begin
    int n, jitter, phase_kind;
    rst_n            = 1'b0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    points_sent      = 0;
    contours_sent    = 0;
    results_taken    = 0;
    idle_cycles      = 0;
    in_ch.valid      = 1'b0;
    in_ch.point_x    = '0;
    in_ch.point_y    = '0;
    in_ch.last_point = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: all-zero conic, so the gradient is zero and the distance saturates
    send_point(0, 0, 1'b1);
    settle();

    // exact circle: on-curve points give zero, the centre has a zero gradient
    load_circle(2048, 2048, 100, 16, 1'b0, AVG_RST, MAXL_RST);
    send_point(2148, 2048, 1'b0);
    send_point(2048, 2148, 1'b0);
    send_point(1948, 2048, 1'b0);
    send_point(2048, 1948, 1'b1);
    send_point(2048, 2048, 1'b0);
    send_point(2148, 2048, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(4095, 4095, 1'b1);
    settle();

    // limits at the extremes
    load_circle(2048, 2048, 100, 16, 1'b0, 32'd0, 32'd0);
    send_point(2148, 2048, 1'b1);
    settle();
    load_circle(1000, 3000, 400, 20, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(1400, 3000, 1'b0);
    send_point(1000, 3390, 1'b0);
    send_point(4095, 0, 1'b1);
    settle();

    // coefficient extremes, largest quotients
    load_conic(64'sh7FFF_FFFF_FFFF, 64'sh7FFF_FFFF_FFFF, 64'sh7FFF_FFFF_FFFF,
               64'sh7FFF_FFFF_FFFF, 64'sh7FFF_FFFF_FFFF, 64'sh7FFF_FFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(4095, 0, 1'b0);
    send_point(0, 4095, 1'b1);
    settle();
    load_conic(-(longint'(1) << 47), -(longint'(1) << 47), -(longint'(1) << 47),
               -(longint'(1) << 47), -(longint'(1) << 47), 1, 32'd1, 32'd1);
    send_point(4095, 4095, 1'b0);
    send_point(1, 1, 1'b1);
    settle();

    // result side held off while single-point contours keep coming, so the block backs up
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++)
      send_point($urandom_range(0, 4095), $urandom_range(0, 4095), 1'b1);
    settle();

    // random phases: mostly noisy circles, some arbitrary conics and junk points
    while (points_sent < 2000) begin
      if (points_sent > 1800) calm = 1'b1;
      phase_kind = $urandom_range(0, 9);
      if (phase_kind < 7) begin
        load_circle($urandom_range(500, 3500), $urandom_range(500, 3500),
                    $urandom_range(10, 400), $urandom_range(8, 20), $urandom_range(0, 1),
                    pick_limit(), pick_limit());
      end else begin
        load_conic(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                   rand_coef(), pick_limit(), pick_limit());
      end
      jitter = $urandom_range(0, 3);
      repeat ($urandom_range(3, 8)) begin
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
          if (phase_kind < 7 && $urandom_range(0, 9) != 0)
            send_circle_point(i == n - 1, jitter);
          else
            send_point($urandom_range(0, 4095), $urandom_range(0, 4095), i == n - 1);
        end
      end
      settle();
    end

    $display("covered %0d point requests in %0d contours, %0d results checked",
             points_sent, contours_sent, results_taken);
    $display("circle and arbitrary conics, limit extremes, zero gradient and a long output stall");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+design
design/csec_pkg.sv
design/csec_in_if.sv
design/csec_out_if.sv
design/csec_mac.sv
design/csec_div.sv
design/contour_sampson_ellipse_check.sv
tb/sv/contour_sampson_ellipse_check_scoreboard.sv
tb/sv/contour_sampson_ellipse_check_tb.sv
